### src/scd_pkg.sv
// shared types and constants of the cache directory
package scd_pkg;

    // access codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // fixed widths of the result fields
    localparam int WAY_W  = 2;
    localparam int VTAG_W = 9;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_full;
    } status_t;

endpackage

### src/scd_ctrl.sv
// controller state machine of the cache directory
module scd_ctrl import scd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd.clear_wr = 1'b0;
        cmd.capture  = 1'b0;
        cmd.commit   = 1'b0;
        s_ready      = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // wait until the result register can take the beat
                if (!status.out_full) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

### src/scd_datapath.sv
// directory memories, tag compare, victim choice and result register
module scd_datapath import scd_pkg::*; #(
    parameter int NUM_SETS    = 16,
    parameter int NUM_WAYS    = 4,
    parameter int OFFSET_BITS = 7,
    parameter int ADDR_BITS   = 20
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output status_t              status,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 s_opcode,
    input  logic [ADDR_BITS-1:0] s_access_address,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_hit,
    output logic [WAY_W-1:0]     m_way,
    output logic                 m_writeback,
    output logic [VTAG_W-1:0]    m_victim_tag
);

    localparam int SET_BITS = $clog2(NUM_SETS);
    localparam int SET_IW   = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int TAG_RAW  = ADDR_BITS - OFFSET_BITS - SET_BITS;
    localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int WB       = $clog2(NUM_WAYS);
    localparam int META_W   = NUM_WAYS * (3 + WB);
    localparam int TROW_W   = NUM_WAYS * TAG_W;
    localparam logic [SET_IW-1:0] SET_MASK = SET_IW'((64'd1 << SET_BITS) - 64'd1);
    localparam logic [SET_IW:0]   SETS_C   = (SET_IW + 1)'(NUM_SETS);
    localparam logic [SET_IW-1:0] LAST_SET = SET_IW'(NUM_SETS - 1);
    localparam logic [WB-1:0]     TOP_RANK = WB'(NUM_WAYS - 1);

    // meta row layout: mru | ranks | dirty | valid
    localparam int V_LO = 0;
    localparam int D_LO = NUM_WAYS;
    localparam int R_LO = 2 * NUM_WAYS;
    localparam int M_LO = 2 * NUM_WAYS + NUM_WAYS * WB;

    logic [META_W-1:0] meta_mem [NUM_SETS];
    logic [TROW_W-1:0] tag_mem  [NUM_SETS];

    logic [META_W-1:0] meta_rd_reg;
    logic [TROW_W-1:0] tag_rd_reg;
    logic [SET_IW-1:0] set_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic              write_reg;
    logic [SET_IW-1:0] clr_idx_reg;
    logic              mode_reg;

    logic              m_valid_reg, m_valid_next;
    logic              hit_reg;
    logic [WAY_W-1:0]  way_reg;
    logic              wb_reg;
    logic [VTAG_W-1:0] vtag_reg;

    // address split of the incoming beat
    logic [ADDR_BITS-1:0] addr_shift;
    logic [SET_IW-1:0]    set_raw;
    logic [SET_IW-1:0]    in_set;
    logic [TAG_W-1:0]     in_tag;

    always_comb begin
        addr_shift = s_access_address >> OFFSET_BITS;
        set_raw    = SET_IW'(addr_shift) & SET_MASK;
        // set field is below twice the set count: one compare and subtract
        if ({1'b0, set_raw} >= SETS_C) begin
            in_set = set_raw - SET_IW'(NUM_SETS);
        end else begin
            in_set = set_raw;
        end
        in_tag = TAG_W'(s_access_address >> (OFFSET_BITS + SET_BITS));
    end

    // unpacked row
    logic [NUM_WAYS-1:0] valid_row, dirty_row, mru_row;
    logic [WB-1:0]       rank_row [NUM_WAYS];
    logic [TAG_W-1:0]    tag_row  [NUM_WAYS];

    logic [NUM_WAYS-1:0] match, lru_win;
    logic                hit;
    logic                any_invalid;
    logic [WB-1:0]       hit_way, inv_way, clr_way, lru_way, victim, way_sel;
    logic                writeback;
    logic [VTAG_W-1:0]   vtag;

    logic [NUM_WAYS-1:0] valid_new, dirty_new, mru_tmp, mru_set, mru_new, sel_oh;
    logic [WB-1:0]       rank_new [NUM_WAYS];
    logic [WB-1:0]       sel_rank;
    logic [META_W-1:0]   meta_new;
    logic [TROW_W-1:0]   tag_new;

    always_comb begin
        valid_row = meta_rd_reg[V_LO +: NUM_WAYS];
        dirty_row = meta_rd_reg[D_LO +: NUM_WAYS];
        mru_row   = meta_rd_reg[M_LO +: NUM_WAYS];
        for (int i = 0; i < NUM_WAYS; i++) begin
            rank_row[i] = meta_rd_reg[R_LO + i*WB +: WB];
            tag_row[i]  = tag_rd_reg[i*TAG_W +: TAG_W];
            match[i]    = valid_row[i] && (tag_row[i] == tag_reg);
        end

        // lowest-numbered way with the smallest rank, by pairwise compares
        for (int i = 0; i < NUM_WAYS; i++) begin
            lru_win[i] = 1'b1;
            for (int j = 0; j < NUM_WAYS; j++) begin
                if (j < i && rank_row[i] >= rank_row[j]) begin
                    lru_win[i] = 1'b0;
                end
                if (j > i && rank_row[i] > rank_row[j]) begin
                    lru_win[i] = 1'b0;
                end
            end
        end

        hit         = |match;
        any_invalid = ~&valid_row;
        hit_way     = '0;
        inv_way     = '0;
        clr_way     = '0;
        lru_way     = '0;
        for (int i = NUM_WAYS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_way = WB'(i);
            end
            if (!valid_row[i]) begin
                inv_way = WB'(i);
            end
            if (!mru_row[i]) begin
                clr_way = WB'(i);
            end
            if (lru_win[i]) begin
                lru_way = WB'(i);
            end
        end

        if (any_invalid) begin
            victim = inv_way;
        end else if (mode_reg) begin
            victim = clr_way;
        end else begin
            victim = lru_way;
        end
        way_sel = hit ? hit_way : victim;

        writeback = !hit && valid_row[way_sel] && dirty_row[way_sel];
        vtag      = writeback ? VTAG_W'(tag_row[way_sel]) : '0;

        valid_new = valid_row;
        dirty_new = dirty_row;
        mru_tmp   = mru_row;
        tag_new   = tag_rd_reg;
        if (hit) begin
            if (write_reg == OP_WRITE) begin
                dirty_new[way_sel] = 1'b1;
            end
        end else begin
            valid_new[way_sel]                = 1'b1;
            dirty_new[way_sel]                = (write_reg == OP_WRITE);
            mru_tmp[way_sel]                  = 1'b0;
            tag_new[way_sel*TAG_W +: TAG_W]   = tag_reg;
        end

        // recency update of the accessed way
        sel_oh   = '0;
        sel_oh[way_sel] = 1'b1;
        sel_rank = rank_row[way_sel];
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (sel_oh[i]) begin
                rank_new[i] = TOP_RANK;
            end else if (rank_row[i] > sel_rank) begin
                rank_new[i] = rank_row[i] - WB'(1);
            end else begin
                rank_new[i] = rank_row[i];
            end
        end
        mru_set = mru_tmp | sel_oh;
        mru_new = (&mru_set) ? sel_oh : mru_set;

        meta_new = '0;
        meta_new[V_LO +: NUM_WAYS] = valid_new;
        meta_new[D_LO +: NUM_WAYS] = dirty_new;
        meta_new[M_LO +: NUM_WAYS] = mru_new;
        for (int i = 0; i < NUM_WAYS; i++) begin
            meta_new[R_LO + i*WB +: WB] = rank_new[i];
        end
    end

    // directory memories: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.clear_wr) begin
            meta_mem[clr_idx_reg] <= '0;
        end else if (cmd.commit) begin
            meta_mem[set_reg] <= meta_new;
        end
        if (cmd.capture) begin
            meta_rd_reg <= meta_mem[in_set];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && !hit) begin
            tag_mem[set_reg] <= tag_new;
        end
        if (cmd.capture) begin
            tag_rd_reg <= tag_mem[in_set];
        end
    end

    // beat fields held for the lookup cycle
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            set_reg   <= in_set;
            tag_reg   <= in_tag;
            write_reg <= s_opcode;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
            mode_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear_wr) begin
                clr_idx_reg <= clr_idx_reg + SET_IW'(1);
            end
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            hit_reg  <= hit;
            way_reg  <= WAY_W'(way_sel);
            wb_reg   <= writeback;
            vtag_reg <= vtag;
        end
    end

    assign status.clear_last = (clr_idx_reg == LAST_SET);
    assign status.out_full   = m_valid_reg && !m_ready;

    assign m_valid      = m_valid_reg;
    assign m_hit        = hit_reg;
    assign m_way        = way_reg;
    assign m_writeback  = wb_reg;
    assign m_victim_tag = vtag_reg;

endmodule

### src/set_assoc_cache_directory.sv
// Tag and replacement directory of a set-associative write-back cache. Each
// input beat carries a read/write code and a byte address; each gives one
// result beat with hit, way, and the tag of a dirty victim to write back.
// An access first reads the set's tag and state rows into registers, then
// does tag compare, victim choice and the row write-back, waiting while the
// result register is full; it lets the next access be taken while a result
// waits. After reset the state memory is cleared one set per cycle, with
// s_ready low. replace_mode (cfg_wdata): 0 true LRU, 1 bit pseudo-LRU.
module set_assoc_cache_directory import scd_pkg::*; #(
    parameter int NUM_SETS    = 16,
    parameter int NUM_WAYS    = 4,
    parameter int OFFSET_BITS = 7,
    parameter int ADDR_BITS   = 20
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  logic [ADDR_BITS-1:0] s_access_address,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_hit,
    output logic [WAY_W-1:0]     m_way,
    output logic                 m_writeback,
    output logic [VTAG_W-1:0]    m_victim_tag
);

    cmd_t    cmd;
    status_t status;

    scd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    scd_datapath #(
        .NUM_SETS    (NUM_SETS),
        .NUM_WAYS    (NUM_WAYS),
        .OFFSET_BITS (OFFSET_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_opcode         (s_opcode),
        .s_access_address (s_access_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hit            (m_hit),
        .m_way            (m_way),
        .m_writeback      (m_writeback),
        .m_victim_tag     (m_victim_tag)
    );

endmodule
